FILE: rtl/pfc_pkg.sv
// pfc_pkg: format codes, configuration register indexes and the conversion result type
// shared by the pixel format converter modules and channel interfaces; no dependencies
package pfc_pkg;

  localparam int unsigned PIXEL_W = 32;
  localparam int unsigned FMT_W   = 3;
  localparam int unsigned NBYTE_W = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_FORMAT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_FORMAT   = 1'b1;

  typedef enum logic [FMT_W-1:0] {
    FMT_RGBA8888 = 3'd0,
    FMT_RGB888   = 3'd1,
    FMT_ARGB1555 = 3'd2,
    FMT_RGB565   = 3'd3,
    FMT_BGR888   = 3'd4
  } fmt_t;

  localparam logic [NBYTE_W-1:0] NBYTES_NONE = 3'd0;
  localparam logic [NBYTE_W-1:0] NBYTES_16   = 3'd2;
  localparam logic [NBYTE_W-1:0] NBYTES_24   = 3'd3;
  localparam logic [NBYTE_W-1:0] NBYTES_32   = 3'd4;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_out;
    logic [NBYTE_W-1:0] valid_bytes;
    logic               unsupported;
  } conv_result_t;

endpackage

FILE: rtl/pfc_if.sv
// pfc_if: valid/ready channel interfaces for source pixels and converted pixels
// depends on pfc_pkg for field widths
interface pfc_in_if;
  logic                          valid;
  logic                          ready;
  logic [pfc_pkg::PIXEL_W-1:0]   pixel_in;
  logic                          last_pixel;

  modport source (output valid, output pixel_in, output last_pixel, input ready);
  modport sink (input valid, input pixel_in, input last_pixel, output ready);
endinterface

interface pfc_out_if;
  logic                          valid;
  logic                          ready;
  logic [pfc_pkg::PIXEL_W-1:0]   pixel_out;
  logic [pfc_pkg::NBYTE_W-1:0]   valid_bytes;
  logic                          unsupported;
  logic                          last_out;

  modport source (output valid, output pixel_out, output valid_bytes, output unsupported,
                  output last_out, input ready);
  modport sink (input valid, input pixel_out, input valid_bytes, input unsupported,
                input last_out, output ready);
endinterface

FILE: rtl/pfc_convert.sv
// pfc_convert: combinational conversion of one pixel between the supported formats
// depends on pfc_pkg for format codes and the result struct
module pfc_convert (
  input  pfc_pkg::fmt_t                src_fmt,
  input  pfc_pkg::fmt_t                dst_fmt,
  input  logic [pfc_pkg::PIXEL_W-1:0]  pixel,
  output pfc_pkg::conv_result_t        result
);

  logic [15:0] c;
  logic [23:0] rgb_swap;
  logic [7:0]  r15, g15, b15;
  logic [7:0]  r565, g565, b565;
  logic [7:0]  rx, gx, bx;
  logic [7:0]  alpha1555;

  assign c        = pixel[15:0];
  assign rgb_swap = {pixel[7:0], pixel[15:8], pixel[23:16]};

  // 1555 fields shifted up, low bits zero
  assign r15 = {c[14:10], 3'b000};
  assign g15 = {c[9:5], 3'b000};
  assign b15 = {c[4:0], 3'b000};

  assign r565 = {c[15:11], 3'b000};
  assign g565 = {c[10:5], 2'b00};
  assign b565 = {c[4:0], 3'b000};

  // bit replication, used only for 1555 to rgba
  assign rx = {c[14:10], c[14:12]};
  assign gx = {c[9:5], c[9:7]};
  assign bx = {c[4:0], c[4:2]};
  assign alpha1555 = c[15] ? pfc_pkg::ALPHA_OPAQUE : 8'h00;

  always_comb begin
    result.pixel_out   = '0;
    result.valid_bytes = pfc_pkg::NBYTES_NONE;
    result.unsupported = 1'b1;
    unique case (src_fmt)
      pfc_pkg::FMT_RGBA8888: begin
        unique case (dst_fmt)
          pfc_pkg::FMT_RGBA8888: begin
            result = '{pixel, pfc_pkg::NBYTES_32, 1'b0};
          end
          pfc_pkg::FMT_RGB888: begin
            result = '{{8'h00, pixel[23:0]}, pfc_pkg::NBYTES_24, 1'b0};
          end
          pfc_pkg::FMT_BGR888: begin
            result = '{{8'h00, rgb_swap}, pfc_pkg::NBYTES_24, 1'b0};
          end
          default: ;
        endcase
      end
      pfc_pkg::FMT_RGB888: begin
        unique case (dst_fmt)
          pfc_pkg::FMT_RGBA8888: begin
            result = '{{pfc_pkg::ALPHA_OPAQUE, pixel[23:0]}, pfc_pkg::NBYTES_32, 1'b0};
          end
          pfc_pkg::FMT_RGB888: begin
            result = '{{8'h00, pixel[23:0]}, pfc_pkg::NBYTES_24, 1'b0};
          end
          pfc_pkg::FMT_BGR888: begin
            result = '{{8'h00, rgb_swap}, pfc_pkg::NBYTES_24, 1'b0};
          end
          default: ;
        endcase
      end
      pfc_pkg::FMT_ARGB1555: begin
        unique case (dst_fmt)
          pfc_pkg::FMT_RGBA8888: begin
            result = '{{alpha1555, rx, gx, bx}, pfc_pkg::NBYTES_32, 1'b0};
          end
          pfc_pkg::FMT_RGB888: begin
            result = '{{8'h00, r15, g15, b15}, pfc_pkg::NBYTES_24, 1'b0};
          end
          pfc_pkg::FMT_ARGB1555: begin
            result = '{{16'h0000, c}, pfc_pkg::NBYTES_16, 1'b0};
          end
          pfc_pkg::FMT_BGR888: begin
            result = '{{8'h00, b15, g15, r15}, pfc_pkg::NBYTES_24, 1'b0};
          end
          default: ;
        endcase
      end
      pfc_pkg::FMT_RGB565: begin
        unique case (dst_fmt)
          pfc_pkg::FMT_RGB888: begin
            result = '{{8'h00, r565, g565, b565}, pfc_pkg::NBYTES_24, 1'b0};
          end
          pfc_pkg::FMT_ARGB1555: begin
            // green lsb dropped, alpha set
            result = '{{16'h0000, 1'b1, c[15:6], c[4:0]}, pfc_pkg::NBYTES_16, 1'b0};
          end
          pfc_pkg::FMT_BGR888: begin
            result = '{{8'h00, b565, g565, r565}, pfc_pkg::NBYTES_24, 1'b0};
          end
          default: ;
        endcase
      end
      pfc_pkg::FMT_BGR888: begin
        unique case (dst_fmt)
          pfc_pkg::FMT_RGBA8888: begin
            result = '{{pfc_pkg::ALPHA_OPAQUE, rgb_swap}, pfc_pkg::NBYTES_32, 1'b0};
          end
          pfc_pkg::FMT_RGB888: begin
            result = '{{8'h00, rgb_swap}, pfc_pkg::NBYTES_24, 1'b0};
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/pixel_format_converter_core.sv
// pixel_format_converter_core: top level, input register, converter and output register
// depends on pfc_pkg, pfc_if (channel interfaces) and pfc_convert

// Converts one pixel per clock between RGBA8888, RGB888, BGR888, ARGB1555 and RGB565,
// with source and destination formats taken from two configuration registers (index 0
// source, index 1 destination, codes 0..4; other codes and unlisted pairs give
// unsupported=1 with a zero pixel and zero valid bytes). Pixels enter and leave as
// little-endian words; bytes above valid_bytes are zero and last_out follows last_pixel.
// An item passes from acceptance through the input register and through the converter
// into the output register. Both stages advance together, so with the output taken every
// cycle the block accepts one pixel per clock. While a result waits at the output, the
// input register still takes one more item and then input ready drops; input ready
// follows output ready combinationally once both registers are full.
// Change the formats only while no pixel is in flight.
module pixel_format_converter_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [pfc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pfc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  pfc_in_if.sink                               pix_in,
  pfc_out_if.source                            pix_out
);

  pfc_pkg::fmt_t               source_format;
  pfc_pkg::fmt_t               dest_format;

  logic                        s1_valid;
  logic [pfc_pkg::PIXEL_W-1:0] s1_pixel;
  logic                        s1_last;

  logic                        out_valid;
  pfc_pkg::conv_result_t       out_result;
  logic                        out_last;

  pfc_pkg::conv_result_t       conv;
  logic                        out_load;
  logic                        in_accept;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= pfc_pkg::FMT_RGBA8888;
      dest_format   <= pfc_pkg::FMT_RGBA8888;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pfc_pkg::REG_SOURCE_FORMAT: source_format <= pfc_pkg::fmt_t'(cfg_wdata);
        pfc_pkg::REG_DEST_FORMAT:   dest_format   <= pfc_pkg::fmt_t'(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign out_load     = s1_valid && (!out_valid || pix_out.ready);
  assign pix_in.ready = !s1_valid || out_load;
  assign in_accept    = pix_in.valid && pix_in.ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_in.ready) begin
      s1_valid <= pix_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pixel <= pix_in.pixel_in;
      s1_last  <= pix_in.last_pixel;
    end
  end

  pfc_convert u_convert (
    .src_fmt (source_format),
    .dst_fmt (dest_format),
    .pixel   (s1_pixel),
    .result  (conv)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pix_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_result <= conv;
      out_last   <= s1_last;
    end
  end

  assign pix_out.valid       = out_valid;
  assign pix_out.pixel_out   = out_result.pixel_out;
  assign pix_out.valid_bytes = out_result.valid_bytes;
  assign pix_out.unsupported = out_result.unsupported;
  assign pix_out.last_out    = out_last;

`ifndef SYNTHESIS
  a_unsupported_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.unsupported |->
      out_result.pixel_out == '0 && out_result.valid_bytes == pfc_pkg::NBYTES_NONE)
    else $error("unsupported result carries data");

  a_supported_size: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_result.unsupported |->
      out_result.valid_bytes == pfc_pkg::NBYTES_16 ||
      out_result.valid_bytes == pfc_pkg::NBYTES_24 ||
      out_result.valid_bytes == pfc_pkg::NBYTES_32)
    else $error("supported result with bad byte count");

  a_upper_bytes_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.valid_bytes != pfc_pkg::NBYTES_32 |->
      out_result.pixel_out[31:24] == 8'h00 &&
      (out_result.valid_bytes == pfc_pkg::NBYTES_24 || out_result.pixel_out[23:16] == 8'h00))
    else $error("bytes above the pixel size are not zero");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_load |=> s1_valid && $stable(s1_pixel) && $stable(s1_last))
    else $error("input stage lost or changed a stalled item");
`endif

endmodule

FILE: dv/tb.sv
// tb: self-checking testbench for pixel_format_converter_core, one pixel per item
// uses pfc_pkg and the pfc_in_if / pfc_out_if channel interfaces from the rtl
// predicts each conversion from the current format registers and checks results in order
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_ITEMS = 1430;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned DRAIN_CYCLES = 4;
  // codes with no format behind them
  localparam logic [pfc_pkg::FMT_W-1:0] FMT_UNDEF_LO = 3'd5;
  localparam logic [pfc_pkg::FMT_W-1:0] FMT_UNDEF_HI = 3'd7;

  typedef logic [pfc_pkg::PIXEL_W-1:0] word_t;
  typedef logic [pfc_pkg::FMT_W-1:0]   fmt_code_t;

  typedef struct packed {
    logic [pfc_pkg::PIXEL_W-1:0] pixel;
    logic                        last;
  } pixel_item_t;

  typedef struct packed {
    pfc_pkg::conv_result_t res;
    logic                  last;
  } pixel_due_t;

  typedef enum logic [1:0] {RX_OPEN, RX_BUSY_LITTLE, RX_BUSY_MOSTLY, RX_PATTERN} rx_mode_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [pfc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pfc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  pfc_in_if pix_in ();
  pfc_out_if pix_out ();

  pixel_format_converter_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pix_in    (pix_in.sink),
    .pix_out   (pix_out.source)
  );

  // shadow of the format registers
  logic [pfc_pkg::FMT_W-1:0] src_fmt;
  logic [pfc_pkg::FMT_W-1:0] dst_fmt;

  pixel_item_t pixels_to_send[$];
  pixel_due_t  pixels_due[$];

  int unsigned mismatches;
  int unsigned pixels_accepted;
  int unsigned pixels_checked;
  int unsigned unsupported_seen;
  int unsigned format_settings;
  int unsigned cycles;

  function automatic pfc_pkg::conv_result_t converted_pixel(fmt_code_t src, fmt_code_t dst,
                                                            word_t p);
    pfc_pkg::conv_result_t r;
    logic [15:0] c;
    logic [7:0] r8, g8, b8;
    logic [pfc_pkg::PIXEL_W-1:0] px;
    logic [pfc_pkg::NBYTE_W-1:0] nb;
    c = p[15:0];
    px = '0;
    nb = pfc_pkg::NBYTES_NONE;
    case (src)
      pfc_pkg::FMT_RGBA8888: begin
        case (dst)
          pfc_pkg::FMT_RGBA8888: begin px = p; nb = pfc_pkg::NBYTES_32; end
          pfc_pkg::FMT_RGB888: begin px = {8'h00, p[23:0]}; nb = pfc_pkg::NBYTES_24; end
          pfc_pkg::FMT_BGR888: begin
            px = {8'h00, p[7:0], p[15:8], p[23:16]};
            nb = pfc_pkg::NBYTES_24;
          end
          default: ;
        endcase
      end
      pfc_pkg::FMT_RGB888: begin
        case (dst)
          pfc_pkg::FMT_RGBA8888: begin
            px = {pfc_pkg::ALPHA_OPAQUE, p[23:0]};
            nb = pfc_pkg::NBYTES_32;
          end
          pfc_pkg::FMT_RGB888: begin px = {8'h00, p[23:0]}; nb = pfc_pkg::NBYTES_24; end
          pfc_pkg::FMT_BGR888: begin
            px = {8'h00, p[7:0], p[15:8], p[23:16]};
            nb = pfc_pkg::NBYTES_24;
          end
          default: ;
        endcase
      end
      pfc_pkg::FMT_ARGB1555: begin
        r8 = {c[14:10], 3'b000};
        g8 = {c[9:5], 3'b000};
        b8 = {c[4:0], 3'b000};
        case (dst)
          pfc_pkg::FMT_RGBA8888: begin
            // low bits filled by replicating the top bits, alpha bit to 0x00 or 0xff
            px = {{8{c[15]}}, c[14:10], c[14:12], c[9:5], c[9:7], c[4:0], c[4:2]};
            nb = pfc_pkg::NBYTES_32;
          end
          pfc_pkg::FMT_RGB888: begin px = {8'h00, r8, g8, b8}; nb = pfc_pkg::NBYTES_24; end
          pfc_pkg::FMT_ARGB1555: begin px = {16'h0000, c}; nb = pfc_pkg::NBYTES_16; end
          pfc_pkg::FMT_BGR888: begin px = {8'h00, b8, g8, r8}; nb = pfc_pkg::NBYTES_24; end
          default: ;
        endcase
      end
      pfc_pkg::FMT_RGB565: begin
        r8 = {c[15:11], 3'b000};
        g8 = {c[10:5], 2'b00};
        b8 = {c[4:0], 3'b000};
        case (dst)
          pfc_pkg::FMT_RGB888: begin px = {8'h00, r8, g8, b8}; nb = pfc_pkg::NBYTES_24; end
          // green lsb dropped, alpha forced on
          pfc_pkg::FMT_ARGB1555: begin
            px = {16'h0000, 1'b1, c[15:6], c[4:0]};
            nb = pfc_pkg::NBYTES_16;
          end
          pfc_pkg::FMT_BGR888: begin px = {8'h00, b8, g8, r8}; nb = pfc_pkg::NBYTES_24; end
          default: ;
        endcase
      end
      pfc_pkg::FMT_BGR888: begin
        case (dst)
          pfc_pkg::FMT_RGBA8888: begin
            px = {pfc_pkg::ALPHA_OPAQUE, p[7:0], p[15:8], p[23:16]};
            nb = pfc_pkg::NBYTES_32;
          end
          pfc_pkg::FMT_RGB888: begin
            px = {8'h00, p[7:0], p[15:8], p[23:16]};
            nb = pfc_pkg::NBYTES_24;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    r.unsupported = (nb == pfc_pkg::NBYTES_NONE);
    r.valid_bytes = nb;
    r.pixel_out = r.unsupported ? '0 : px;
    return r;
  endfunction

  function automatic word_t random_pixel();
    word_t one_hot;
    one_hot = 32'h1 << $urandom_range(0, pfc_pkg::PIXEL_W - 1);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return one_hot;
      3: return ~one_hot;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // sender: bursts of random length separated by random gaps
  int unsigned burst_left;
  int unsigned gap_left;
  pixel_item_t next_item;

  always @(posedge clk) begin
    if (rst) begin
      pix_in.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (pix_in.valid && pix_in.ready) begin
        pixels_due.push_back({converted_pixel(src_fmt, dst_fmt, pix_in.pixel_in),
                              pix_in.last_pixel});
        pixels_accepted++;
      end
      if (!pix_in.valid || pix_in.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          pix_in.valid <= 1'b0;
        end else if (pixels_to_send.size() == 0) begin
          pix_in.valid <= 1'b0;
        end else begin
          next_item = pixels_to_send.pop_front();
          pix_in.valid <= 1'b1;
          pix_in.pixel_in <= next_item.pixel;
          pix_in.last_pixel <= next_item.last;
          if (burst_left > 0)
            burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // receiver: stall behavior switches between a few modes
  rx_mode_t rx_mode;
  int unsigned rx_mode_left;
  logic [7:0] rx_mask;

  always @(posedge clk) begin
    if (rst) begin
      pix_out.ready <= 1'b0;
      rx_mode_left = 0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(8, 64);
        rx_mask = 8'($urandom);
      end
      rx_mode_left--;
      case (rx_mode)
        RX_OPEN: pix_out.ready <= 1'b1;
        RX_BUSY_LITTLE: pix_out.ready <= ($urandom_range(0, 3) != 0);
        RX_BUSY_MOSTLY: pix_out.ready <= ($urandom_range(0, 3) == 0);
        default: begin
          pix_out.ready <= rx_mask[0];
          rx_mask = {rx_mask[0], rx_mask[7:1]};
        end
      endcase
    end
  end

  task automatic check_field(string name, word_t expected, word_t actual);
    if (expected !== actual) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch on %s at pixel %0d: expected %h, got %h",
                 name, pixels_checked, expected, actual);
    end
  endtask

  pixel_due_t due;

  always @(posedge clk) begin
    if (!rst && pix_out.valid && pix_out.ready) begin
      if (pixels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: pixel_out %h valid_bytes %0d",
                   pix_out.pixel_out, pix_out.valid_bytes);
      end else begin
        due = pixels_due.pop_front();
        check_field("pixel_out", due.res.pixel_out, pix_out.pixel_out);
        check_field("valid_bytes", word_t'(due.res.valid_bytes),
                    word_t'(pix_out.valid_bytes));
        check_field("unsupported", word_t'(due.res.unsupported),
                    word_t'(pix_out.unsupported));
        check_field("last_out", word_t'(due.last), word_t'(pix_out.last_out));
        if (due.res.unsupported)
          unsupported_seen++;
        pixels_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pixels_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (pixels_to_send.size() != 0 || pix_in.valid || pixels_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // only called with the pipeline empty
  task automatic set_formats(fmt_code_t src, fmt_code_t dst);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= pfc_pkg::REG_SOURCE_FORMAT;
    cfg_wdata <= src;
    @(posedge clk);
    cfg_index <= pfc_pkg::REG_DEST_FORMAT;
    cfg_wdata <= dst;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    src_fmt = src;
    dst_fmt = dst;
    format_settings++;
  endtask

  task automatic send_pixel(word_t pixel, logic last);
    pixels_to_send.push_back({pixel, last});
  endtask

  task automatic send_random(int unsigned count);
    repeat (count) send_pixel(random_pixel(), $urandom_range(0, 7) == 0);
    wait_drained();
  endtask

  fmt_code_t rand_src;
  fmt_code_t rand_dst;

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = pfc_pkg::REG_SOURCE_FORMAT;
    cfg_wdata = '0;
    pix_in.valid = 1'b0;
    pix_in.pixel_in = '0;
    pix_in.last_pixel = 1'b0;
    pix_out.ready = 1'b0;
    src_fmt = pfc_pkg::FMT_RGBA8888;
    dst_fmt = pfc_pkg::FMT_RGBA8888;
    mismatches = 0;
    pixels_accepted = 0;
    pixels_checked = 0;
    unsupported_seen = 0;
    format_settings = 1;
    cycles = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // formats as they come out of reset
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'hffff_ffff, 1'b1);
    send_pixel(32'h1234_5678, 1'b0);
    send_pixel(32'h8000_0001, 1'b1);
    wait_drained();

    // alpha bit both ways, upper half ignored
    set_formats(pfc_pkg::FMT_ARGB1555, pfc_pkg::FMT_RGBA8888);
    send_pixel(32'h0000_8000, 1'b0);
    send_pixel(32'h0000_7fff, 1'b0);
    send_pixel(32'hffff_0000, 1'b1);
    send_pixel(32'h0000_0421, 1'b0);
    wait_drained();

    // lone green lsb is lost, alpha always set
    set_formats(pfc_pkg::FMT_RGB565, pfc_pkg::FMT_ARGB1555);
    send_pixel(32'h0000_0020, 1'b0);
    send_pixel(32'hffff_ffff, 1'b1);
    send_pixel(32'h0000_0000, 1'b0);
    wait_drained();

    set_formats(pfc_pkg::FMT_RGB888, pfc_pkg::FMT_BGR888);
    send_pixel(32'haabb_ccdd, 1'b0);
    wait_drained();
    set_formats(pfc_pkg::FMT_BGR888, pfc_pkg::FMT_RGBA8888);
    send_pixel(32'h0011_2233, 1'b1);
    wait_drained();

    // same-format pairs that have no conversion, and undefined codes
    set_formats(pfc_pkg::FMT_RGB565, pfc_pkg::FMT_RGB565);
    send_pixel(32'hffff_ffff, 1'b1);
    wait_drained();
    set_formats(pfc_pkg::FMT_BGR888, pfc_pkg::FMT_BGR888);
    send_pixel(32'h0012_3456, 1'b0);
    wait_drained();
    set_formats(FMT_UNDEF_HI, pfc_pkg::FMT_RGBA8888);
    send_pixel(32'hffff_ffff, 1'b1);
    wait_drained();
    set_formats(pfc_pkg::FMT_RGBA8888, FMT_UNDEF_LO);
    send_pixel(32'h0000_0001, 1'b0);
    wait_drained();

    // every pair of codes, defined or not
    for (int s = 0; s < 8; s++)
      for (int d = 0; d < 8; d++) begin
        set_formats(s[pfc_pkg::FMT_W-1:0], d[pfc_pkg::FMT_W-1:0]);
        send_random(6);
      end

    // random settings, mostly among the defined formats
    while (pixels_accepted < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0: begin
          rand_src = fmt_code_t'($urandom_range(FMT_UNDEF_LO, FMT_UNDEF_HI));
          rand_dst = fmt_code_t'($urandom_range(0, 7));
        end
        1: begin
          rand_src = fmt_code_t'($urandom_range(0, 7));
          rand_dst = fmt_code_t'($urandom_range(FMT_UNDEF_LO, FMT_UNDEF_HI));
        end
        default: begin
          rand_src = fmt_code_t'($urandom_range(pfc_pkg::FMT_RGBA8888, pfc_pkg::FMT_BGR888));
          rand_dst = fmt_code_t'($urandom_range(pfc_pkg::FMT_RGBA8888, pfc_pkg::FMT_BGR888));
        end
      endcase
      set_formats(rand_src, rand_dst);
      send_random($urandom_range(10, 60));
    end

    wait_drained();
    if (pixels_due.size() != 0)
      mismatches++;
    $display("converted %0d pixels under %0d format settings, %0d of them unsupported",
             pixels_checked, format_settings, unsupported_seen);
    $display("%0d mismatches in %0d cycles", mismatches, cycles);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
